// ----- src/mpts_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpts_pkg: shared types and constants of the priority thread scheduler
// Command codes, table sizes and field widths.
// ---------------------------------------------------------------------------
package mpts_pkg;

  localparam int Levels     = 32;
  localparam int MaxThreads = 32;
  localparam int LvW        = $clog2(Levels);
  localparam int TidW       = $clog2(MaxThreads);

  typedef enum logic [1:0] {
    CMD_READY    = 2'd0,
    CMD_SET_PRIO = 2'd1,
    CMD_QUANTUM  = 2'd2,
    CMD_SWITCH   = 2'd3
  } cmd_t;

endpackage

// ----- src/mpts_scan.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpts_scan: level scan unit
// Walks the non-empty bits from the top level down, one level per cycle,
// and reports the highest non-empty level at or above a floor.
// ---------------------------------------------------------------------------
module mpts_scan
  import mpts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LvW-1:0]    floor_lv,
  input  logic [Levels-1:0] nonempty,
  output logic              done,
  output logic              found,
  output logic [LvW-1:0]    level
);

  logic           busy;
  logic [LvW-1:0] cur;

  // one level checked each cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
      cur   <= '0;
      level <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        found <= 1'b0;
        cur   <= LvW'(Levels - 1);
      end else if (busy) begin
        if (nonempty[cur]) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          found <= 1'b1;
          level <= cur;
        end else if (cur <= floor_lv) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cur <= cur - 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/multilevel_priority_thread_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multilevel_priority_thread_scheduler_unit
// Per-level FIFO ready queues of thread ids with quantum-end and switch.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one word: command,
//   thread_id, priority_req. Each word yields one result word on the output
//   channel (out_valid/out_ready): current_id, current_valid, need_switch,
//   error.
//   Switch registers its result straight after decode; ready first links a
//   thread that is not yet queued; set-priority of a queued thread unlinks
//   it, then links it at the new level. Quantum end first runs the level
//   scan, one level per cycle, unless a thread is pending, then unlinks the
//   thread found and re-links the running one. One word is in work at a
//   time; the input is ready again the cycle after the result is registered.
//   The result sits in an output register; the next word is accepted while
//   it waits, and the block stalls only when a second result would be due.
//   Reset clears the level bits, queued bits, stored levels and the running
//   and pending thread; links, heads and tails need no reset.
// ---------------------------------------------------------------------------
module multilevel_priority_thread_scheduler_unit
  import mpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [4:0] thread_id,
  input  logic [4:0] priority_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] current_id,
  output logic       current_valid,
  output logic       need_switch,
  output logic       error
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_UNL, S_UNL2, S_LNK, S_REQ, S_DONE
  } state_t;

  state_t state;

  logic [LvW-1:0]    thread_level [MaxThreads];
  logic [TidW-1:0]   next_link    [MaxThreads];
  logic [TidW-1:0]   prev_link    [MaxThreads];
  logic [TidW-1:0]   level_head   [Levels];
  logic [TidW-1:0]   level_tail   [Levels];
  logic [MaxThreads-1:0] queued;
  logic [Levels-1:0] nonempty;

  logic            run_valid, pend_valid;
  logic [TidW-1:0] run_id, pend_id;

  cmd_t            cmd;
  logic [TidW-1:0] tid;
  logic [LvW-1:0]  pri;
  logic            tid_ok;
  logic            at_head;
  logic            err;
  logic            requeue;  // quantum end: re-link running thread after pop

  // saturated priority and id range check
  logic [LvW-1:0] pri_sat;
  logic           tid_in;
  assign pri_sat = (32'(priority_req) > Levels - 1) ? LvW'(Levels - 1)
                                                     : LvW'(priority_req);
  assign tid_in  = 32'(thread_id) < MaxThreads;

  // scan unit
  logic           scan_start, scan_done, scan_found;
  logic [LvW-1:0] scan_level, scan_floor;
  assign scan_floor = run_valid ? thread_level[run_id] : '0;

  mpts_scan u_scan (
    .clk(clk), .rst(rst), .start(scan_start), .floor_lv(scan_floor),
    .nonempty(nonempty), .done(scan_done), .found(scan_found),
    .level(scan_level)
  );

  assign scan_start = (state == S_DEC) && (cmd == CMD_QUANTUM) && !pend_valid;
  assign in_ready   = (state == S_IDLE);

  // current unlink/link fields of the addressed thread
  logic [LvW-1:0]  lv;
  logic [TidW-1:0] pl, nl, hd, tl;
  assign lv = thread_level[tid];
  assign pl = prev_link[tid];
  assign nl = next_link[tid];
  assign hd = level_head[lv];
  assign tl = level_tail[lv];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      queued     <= '0;
      nonempty   <= '0;
      run_valid  <= 1'b0;
      run_id     <= '0;
      pend_valid <= 1'b0;
      pend_id    <= '0;
      for (int i = 0; i < MaxThreads; i++) thread_level[i] <= '0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd     <= cmd_t'(command);
            tid     <= TidW'(thread_id);
            tid_ok  <= tid_in;
            pri     <= pri_sat;
            err     <= 1'b0;
            requeue <= 1'b0;
            state   <= S_DEC;
          end
        end
        S_DEC: begin
          unique case (cmd)
            CMD_READY: begin
              at_head <= 1'b0;
              state   <= (tid_ok && !queued[tid]) ? S_LNK : S_DONE;
            end
            CMD_SET_PRIO: begin
              if (!tid_ok) state <= S_DONE;
              else if (queued[tid]) begin
                at_head <= thread_level[tid] > pri;
                state   <= S_UNL;
              end else begin
                thread_level[tid] <= pri;
                state <= S_DONE;
              end
            end
            CMD_QUANTUM: state <= pend_valid ? S_DONE : S_SCAN;
            CMD_SWITCH: begin
              if (pend_valid) begin
                run_id     <= pend_id;
                run_valid  <= 1'b1;
                pend_valid <= 1'b0;
                pend_id    <= '0;
              end else begin
                err <= 1'b1;
              end
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end
        S_SCAN: begin
          if (scan_done) begin
            if (scan_found) begin
              tid        <= level_head[scan_level];
              pend_id    <= level_head[scan_level];
              pend_valid <= 1'b1;
              state      <= S_UNL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        // unlink: head fix-up here, tail fix-up in S_UNL2
        S_UNL: begin
          if (hd == tid && tl == tid) nonempty[lv] <= 1'b0;
          else begin
            if (hd == tid) level_head[lv] <= nl; else next_link[pl] <= nl;
          end
          queued[tid] <= 1'b0;
          state <= S_UNL2;
        end
        S_UNL2: begin
          if (!(hd == tid && tl == tid) || !nonempty[lv]) begin
            if (tl == tid && hd != tid) level_tail[lv] <= pl;
            else if (tl != tid)         prev_link[nl]  <= pl;
          end
          if (cmd == CMD_SET_PRIO) begin
            thread_level[tid] <= pri;
            state <= S_LNK;
          end else begin
            // quantum end: unload the running thread
            if (run_valid) begin
              if (run_id != tid && !queued[run_id]) begin
                tid     <= run_id;
                at_head <= 1'b0;
                requeue <= 1'b1;
              end
              run_valid <= 1'b0;
              run_id    <= '0;
            end
            state <= S_REQ;
          end
        end
        S_REQ: state <= requeue ? S_LNK : S_DONE;
        // link at head or tail, the new entry's and its neighbour's pointers at once
        S_LNK: begin
          if (!nonempty[lv]) begin
            level_head[lv] <= tid;
            level_tail[lv] <= tid;
            nonempty[lv]   <= 1'b1;
          end else if (at_head) begin
            prev_link[hd]  <= tid;
            next_link[tid] <= hd;
            level_head[lv] <= tid;
          end else begin
            next_link[tl]  <= tid;
            prev_link[tid] <= tl;
            level_tail[lv] <= tid;
          end
          queued[tid] <= 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            current_id    <= run_valid ? run_id : '0;
            current_valid <= run_valid;
            need_switch   <= pend_valid;
            error         <= err;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mpts_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpts_checker: port-level checks of the scheduler
// Watches the result channel and its relation to the input channel.
// ---------------------------------------------------------------------------
module mpts_checker
  import mpts_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] current_id,
  input logic       current_valid,
  input logic       need_switch,
  input logic       error
);

  // stalled result word holds its current_id and error
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_id) && $stable(error))
    else $error("result word changed while stalled");

  // idle thread slot reads as zero
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !current_valid |-> current_id == '0)
    else $error("current_id nonzero with no thread loaded");

  // an error only comes with no pending thread
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !need_switch)
    else $error("error with pending thread");

  // accepted word is not followed by acceptance next cycle
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted back to back");

endmodule

bind multilevel_priority_thread_scheduler_unit mpts_checker u_mpts_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .current_id(current_id),
  .current_valid(current_valid), .need_switch(need_switch), .error(error)
);

// ----- sim/multilevel_priority_thread_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multilevel_priority_thread_scheduler_unit_tb
// Drives command words into the scheduler, tracks the per-level ready queues
// in a behavioral scoreboard and compares every result word field by field.
// ---------------------------------------------------------------------------
module multilevel_priority_thread_scheduler_unit_tb;
  import mpts_pkg::*;

  typedef struct packed {
    logic [4:0] cur_id;
    logic       cur_vld;
    logic       pend;
    logic       err;
  } sched_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = CMD_READY;
  logic [4:0] thread_id = '0;
  logic [4:0] priority_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [4:0] current_id;
  logic       current_valid;
  logic       need_switch;
  logic       error;

  // scoreboard state
  logic [4:0] lvl_of [MaxThreads];
  bit         queued [MaxThreads];
  logic [4:0] nxt [MaxThreads];
  logic [4:0] prv [MaxThreads];
  logic [4:0] head [Levels];
  logic [4:0] tail [Levels];
  bit         busy_lvl [Levels];
  bit         run_v, pend_v;
  logic [4:0] run_t, pend_t;

  sched_res_t expected_q[$];
  int  fails = 0;
  int  cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;

  multilevel_priority_thread_scheduler_unit DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic dequeue_thread(input logic [4:0] t);
    logic [4:0] lv;
    lv = lvl_of[t];
    if (head[lv] == t && tail[lv] == t) busy_lvl[lv] = 0;
    else begin
      if (head[lv] == t) head[lv] = nxt[t]; else nxt[prv[t]] = nxt[t];
      if (tail[lv] == t) tail[lv] = prv[t]; else prv[nxt[t]] = prv[t];
    end
    queued[t] = 0;
  endtask

  task automatic enqueue_thread(input logic [4:0] t, input bit at_head);
    logic [4:0] lv;
    lv = lvl_of[t];
    if (!busy_lvl[lv]) begin
      head[lv] = t; tail[lv] = t; busy_lvl[lv] = 1;
    end else if (at_head) begin
      prv[head[lv]] = t; nxt[t] = head[lv]; head[lv] = t;
    end else begin
      nxt[tail[lv]] = t; prv[t] = tail[lv]; tail[lv] = t;
    end
    queued[t] = 1;
  endtask

  // scheduler prediction for one accepted word
  task automatic schedule_word(input cmd_t c, input logic [4:0] t, input logic [4:0] p);
    sched_res_t r;
    bit err, found, drop;
    int floor_lv, lv;
    err = 0;
    found = 0;
    case (c)
      CMD_READY: if (!queued[t]) enqueue_thread(t, 0);
      CMD_SET_PRIO: begin
        if (queued[t]) begin
          drop = lvl_of[t] > p;
          dequeue_thread(t);
          lvl_of[t] = p;
          enqueue_thread(t, drop);
        end else lvl_of[t] = p;
      end
      CMD_QUANTUM: begin
        floor_lv = run_v ? int'(lvl_of[run_t]) : 0;
        lv = Levels;
        if (!pend_v) begin
          while (lv > floor_lv && !found) begin
            lv--;
            if (busy_lvl[lv]) found = 1;
          end
        end
        if (found) begin
          pend_t = head[lv];
          pend_v = 1;
          dequeue_thread(pend_t);
          if (run_v) begin
            if (run_t != pend_t && !queued[run_t]) enqueue_thread(run_t, 0);
            run_v = 0;
            run_t = '0;
          end
        end
      end
      default: begin
        if (pend_v) begin
          run_t = pend_t; run_v = 1; pend_v = 0; pend_t = '0;
        end else err = 1;
      end
    endcase
    r.cur_id  = run_v ? run_t : 5'd0;
    r.cur_vld = run_v;
    r.pend    = pend_v;
    r.err     = err;
    expected_q.push_back(r);
  endtask

  // send one word, honoring the sender idle ratio
  task automatic send_word(input cmd_t c, input logic [4:0] t, input logic [4:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= c;
    thread_id    <= t;
    priority_req <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_word(c, t, p);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off  <= hold_off - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (current_id !== e.cur_id) begin
          $error("current_id exp %0d got %0d", e.cur_id, current_id); fails++;
        end
        if (current_valid !== e.cur_vld) begin
          $error("current_valid exp %0d got %0d", e.cur_vld, current_valid); fails++;
        end
        if (need_switch !== e.pend) begin
          $error("need_switch exp %0d got %0d", e.pend, need_switch); fails++;
        end
        if (error !== e.err) begin
          $error("error exp %0d got %0d", e.err, error); fails++;
        end
      end
    end
  end

  task automatic set_idling(input int s, input int r);
    send_idle_pct  = s;
    recv_stall_pct = r;
  endtask

  // one random word, mostly a sensible scheduling mix
  task automatic random_word();
    int k;
    k = $urandom_range(99);
    if (k < 35) send_word(CMD_READY, 5'($urandom_range(31)), 5'($urandom_range(31)));
    else if (k < 55) send_word(CMD_SET_PRIO, 5'($urandom_range(31)),
                               ($urandom_range(3) == 0) ? 5'($urandom_range(31)) :
                               5'($urandom_range(7)));
    else if (k < 78) send_word(CMD_QUANTUM, 5'($urandom_range(31)),
                               5'($urandom_range(31)));
    else send_word(CMD_SWITCH, 5'($urandom_range(31)), 5'($urandom_range(31)));
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_word(CMD_SWITCH, 5'd0, 5'd0);       // switch with nothing pending
    send_word(CMD_QUANTUM, 5'd0, 5'd0);      // nothing eligible
    send_word(CMD_SET_PRIO, 5'd31, 5'd31);   // unqueued, top level
    send_word(CMD_READY, 5'd31, 5'd0);
    send_word(CMD_READY, 5'd31, 5'd0);       // already queued
    send_word(CMD_READY, 5'd0, 5'd31);
    send_word(CMD_READY, 5'd5, 5'd0);
    send_word(CMD_SET_PRIO, 5'd5, 5'd31);    // raise: tail of top level
    send_word(CMD_SET_PRIO, 5'd0, 5'd31);
    send_word(CMD_SET_PRIO, 5'd0, 5'd0);     // drop: head of level zero
    send_word(CMD_QUANTUM, 5'd0, 5'd0);
    send_word(CMD_QUANTUM, 5'd0, 5'd0);      // already pending
    send_word(CMD_SWITCH, 5'd0, 5'd0);
    send_word(CMD_QUANTUM, 5'd0, 5'd0);      // running re-queued
    send_word(CMD_SWITCH, 5'd0, 5'd0);
    send_word(CMD_READY, 5'd5, 5'd0);        // running thread queued too
    send_word(CMD_QUANTUM, 5'd0, 5'd0);      // running thread already queued, not re-linked
    send_word(CMD_SWITCH, 5'd0, 5'd0);
    send_word(CMD_QUANTUM, 5'd0, 5'd0);      // lower levels not eligible
    send_word(CMD_SET_PRIO, 5'd21, 5'd10);
    send_word(CMD_READY, 5'd21, 5'd0);
    send_word(CMD_QUANTUM, 5'd0, 5'd0);
    send_word(CMD_SWITCH, 5'd0, 5'd0);
  endtask

  task automatic test_random(input int n, input int s, input int r);
    set_idling(s, r);
    repeat (n) random_word();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_off = 300;
    repeat (40) random_word();
  endtask

  initial begin
    foreach (lvl_of[i]) begin
      lvl_of[i] = '0; queued[i] = 0; nxt[i] = '0; prv[i] = '0;
    end
    foreach (busy_lvl[i]) begin
      busy_lvl[i] = 0; head[i] = '0; tail[i] = '0;
    end
    run_v = 0; pend_v = 0; run_t = '0; pend_t = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 55, 0);
    test_random(500, 0, 55);
    test_random(460, 14, 14);
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ----- multilevel_priority_thread_scheduler_unit.f -----
src/mpts_pkg.sv
src/mpts_scan.sv
src/multilevel_priority_thread_scheduler_unit.sv
src/mpts_checker.sv
sim/multilevel_priority_thread_scheduler_unit_tb.sv
